// File: rtl/core/pid_pkg.sv
// ----------------------------------------------------------------------------
// pid_pkg
// Shared types and constants of the priority interrupt dispatcher.
// ----------------------------------------------------------------------------
package pid_pkg;

  localparam int unsigned NORMAL_DEPTH_DEF = 16;
  localparam int unsigned LOW_DEPTH_DEF    = 16;

  localparam int unsigned DEV_W     = 3;
  localparam int unsigned CLASS_W   = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned PENDING_W = 5;

  localparam logic [DEV_W-1:0] DEV_LIMIT = 3'd4;

  typedef enum logic [1:0] {
    OP_HIGH   = 2'd0,
    OP_NORMAL = 2'd1,
    OP_LOW    = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [CLASS_W-1:0] {
    CLS_HIGH   = 2'd0,
    CLS_NORMAL = 2'd1,
    CLS_LOW    = 2'd2,
    CLS_NONE   = 2'd3
  } cls_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DISPATCHED = 2'd0,
    STAT_INVALID    = 2'd1,
    STAT_FULL       = 2'd2,
    STAT_UNUSED     = 2'd3
  } status_e;

  localparam logic CMD_POST = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    op_e              op;
    logic [DEV_W-1:0] dev;
  } cmd_t;

  typedef struct packed {
    logic [DEV_W-1:0]     target_device;
    status_e              status;
    cls_e                 served_class;
    logic [PENDING_W-1:0] normal_pending;
    logic [PENDING_W-1:0] low_pending;
  } res_t;

endpackage

// File: rtl/core/priority_interrupt_dispatcher_core.sv
// ----------------------------------------------------------------------------
// priority_interrupt_dispatcher_core
// Strict-priority interrupt dispatcher with a normal and a low FIFO.
// ----------------------------------------------------------------------------
// Items enter through a queue-style port (push/full) and results leave through
// one (empty/pop). A front stage classifies each item into a two-entry command
// queue at one item per cycle while it is not full; the back stage executes one
// command at a time. Posts run in ST_IDLE; a tick that finds an entry also
// passes ST_READ for the registered FIFO memory read. Queued posts, class 3
// posts and ticks on empty FIFOs give no result. Results wait in a two-entry
// output queue, so the back stage runs on while the consumer stalls, until it fills.
module priority_interrupt_dispatcher_core #(
  parameter int unsigned NORMAL_DEPTH = pid_pkg::NORMAL_DEPTH_DEF,
  parameter int unsigned LOW_DEPTH    = pid_pkg::LOW_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       command_i,
  input  logic [1:0] priority_class_i,
  input  logic [2:0] device_code_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] target_device_o,
  output logic [1:0] status_o,
  output logic [1:0] served_class_o,
  output logic [4:0] normal_pending_o,
  output logic [4:0] low_pending_o
);
  import pid_pkg::*;

  logic cmd_valid, cmd_pop, res_valid;
  cmd_t cmd;
  res_t res;

  pid_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .command_i        (command_i),
    .priority_class_i (priority_class_i),
    .device_code_i    (device_code_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  pid_back #(
    .NormalDepth (NORMAL_DEPTH),
    .LowDepth    (LOW_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  assign empty            = !res_valid;
  assign target_device_o  = res.target_device;
  assign status_o         = res.status;
  assign served_class_o   = res.served_class;
  assign normal_pending_o = res.normal_pending;
  assign low_pending_o    = res.low_pending;

endmodule

// File: rtl/core/pid_ram.sv
// ----------------------------------------------------------------------------
// pid_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pid_ram #(
  parameter int unsigned Width = 3,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/pid_front.sv
// ----------------------------------------------------------------------------
// pid_front
// Accepts posts and ticks, classifies them and queues the resulting commands.
// ----------------------------------------------------------------------------
module pid_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic                  command_i,
  input  logic [1:0]            priority_class_i,
  input  logic [2:0]            device_code_i,
  output logic                  cmd_valid_o,
  output pid_pkg::cmd_t         cmd_o,
  input  logic                  cmd_pop_i
);
  import pid_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       accept, keep, do_push, do_pop;
  cmd_t       cls_cmd;

  // classify the incoming item
  always_comb begin
    cls_cmd.dev = device_code_i;
    cls_cmd.op  = OP_TICK;
    keep        = 1'b1;
    if (command_i == CMD_POST) begin
      case (priority_class_i)
        CLS_HIGH:   cls_cmd.op = OP_HIGH;
        CLS_NORMAL: cls_cmd.op = OP_NORMAL;
        CLS_LOW:    cls_cmd.op = OP_LOW;
        default:    keep = 1'b0;
      endcase
    end
  end

  assign full    = (cnt_q == 2'd2);
  assign accept  = push && !full;
  assign do_push = accept && keep;
  assign do_pop  = cmd_pop_i && (cnt_q != 2'd0);

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cls_cmd;
    end
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

endmodule

// File: rtl/core/pid_back.sv
// ----------------------------------------------------------------------------
// pid_back
// Executes queued commands on the normal and low FIFOs and queues results.
// ----------------------------------------------------------------------------
module pid_back #(
  parameter int unsigned NormalDepth = pid_pkg::NORMAL_DEPTH_DEF,
  parameter int unsigned LowDepth    = pid_pkg::LOW_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  pid_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          res_valid_o,
  output pid_pkg::res_t res_o,
  input  logic          res_pop_i
);
  import pid_pkg::*;

  localparam int unsigned NAW = $clog2(NormalDepth);
  localparam int unsigned LAW = $clog2(LowDepth);
  localparam int unsigned NCW = $clog2(NormalDepth + 1);
  localparam int unsigned LCW = $clog2(LowDepth + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  state_e           state_q, state_d;
  cls_e             sel_q, sel_d;
  logic [NAW-1:0]   n_head_q, n_head_d, n_tail_q, n_tail_d;
  logic [NCW-1:0]   n_cnt_q, n_cnt_d;
  logic [LAW-1:0]   l_head_q, l_head_d, l_tail_q, l_tail_d;
  logic [LCW-1:0]   l_cnt_q, l_cnt_d;
  logic             n_we, l_we;
  logic [DEV_W-1:0] n_rdata, l_rdata, rd_dev;
  logic             n_full, l_full;
  logic [NAW-1:0]   n_head_inc, n_tail_inc;
  logic [LAW-1:0]   l_head_inc, l_tail_inc;

  res_t             res_slot_q [2];
  logic             res_wr_q, res_rd_q;
  logic [1:0]       res_cnt_q, res_cnt_d;
  logic             res_push, res_pop, res_room;
  res_t             res_in;

  pid_ram #(.Width(DEV_W), .Depth(NormalDepth)) u_normal_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_tail_q),
    .wdata_i (cmd_i.dev),
    .raddr_i (n_head_q),
    .rdata_o (n_rdata)
  );

  pid_ram #(.Width(DEV_W), .Depth(LowDepth)) u_low_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_tail_q),
    .wdata_i (cmd_i.dev),
    .raddr_i (l_head_q),
    .rdata_o (l_rdata)
  );

  assign n_full     = (n_cnt_q == NCW'(NormalDepth));
  assign l_full     = (l_cnt_q == LCW'(LowDepth));
  assign n_head_inc = (n_head_q == NAW'(NormalDepth - 1)) ? '0 : n_head_q + 1'b1;
  assign n_tail_inc = (n_tail_q == NAW'(NormalDepth - 1)) ? '0 : n_tail_q + 1'b1;
  assign l_head_inc = (l_head_q == LAW'(LowDepth - 1)) ? '0 : l_head_q + 1'b1;
  assign l_tail_inc = (l_tail_q == LAW'(LowDepth - 1)) ? '0 : l_tail_q + 1'b1;
  assign rd_dev     = (sel_q == CLS_NORMAL) ? n_rdata : l_rdata;
  assign res_room   = (res_cnt_q != 2'd2);

  always_comb begin
    state_d   = state_q;
    sel_d     = sel_q;
    n_head_d  = n_head_q;
    n_tail_d  = n_tail_q;
    n_cnt_d   = n_cnt_q;
    l_head_d  = l_head_q;
    l_tail_d  = l_tail_q;
    l_cnt_d   = l_cnt_q;
    n_we      = 1'b0;
    l_we      = 1'b0;
    cmd_pop_o = 1'b0;
    res_push  = 1'b0;
    res_in.target_device  = cmd_i.dev;
    res_in.status         = (cmd_i.dev < DEV_LIMIT) ? STAT_DISPATCHED : STAT_INVALID;
    res_in.served_class   = CLS_HIGH;
    res_in.normal_pending = PENDING_W'(n_cnt_q);
    res_in.low_pending    = PENDING_W'(l_cnt_q);
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && res_room) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            OP_HIGH: begin
              res_push = 1'b1;
            end
            OP_NORMAL: begin
              if (n_full) begin
                res_push            = 1'b1;
                res_in.status       = STAT_FULL;
                res_in.served_class = CLS_NORMAL;
              end else begin
                n_we     = 1'b1;
                n_tail_d = n_tail_inc;
                n_cnt_d  = n_cnt_q + 1'b1;
              end
            end
            OP_LOW: begin
              if (l_full) begin
                res_push            = 1'b1;
                res_in.status       = STAT_FULL;
                res_in.served_class = CLS_LOW;
              end else begin
                l_we     = 1'b1;
                l_tail_d = l_tail_inc;
                l_cnt_d  = l_cnt_q + 1'b1;
              end
            end
            OP_TICK: begin
              if (n_cnt_q != '0) begin
                sel_d    = CLS_NORMAL;
                n_head_d = n_head_inc;
                n_cnt_d  = n_cnt_q - 1'b1;
                state_d  = ST_READ;
              end else if (l_cnt_q != '0) begin
                sel_d    = CLS_LOW;
                l_head_d = l_head_inc;
                l_cnt_d  = l_cnt_q - 1'b1;
                state_d  = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        res_push             = 1'b1;
        res_in.target_device = rd_dev;
        res_in.status        = (rd_dev < DEV_LIMIT) ? STAT_DISPATCHED : STAT_INVALID;
        res_in.served_class  = sel_q;
        state_d              = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result queue
  assign res_pop = res_pop_i && (res_cnt_q != 2'd0);

  always_comb begin
    res_cnt_d = res_cnt_q;
    if (res_push && !res_pop) begin
      res_cnt_d = res_cnt_q + 2'd1;
    end else if (!res_push && res_pop) begin
      res_cnt_d = res_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sel_q     <= CLS_NORMAL;
      n_head_q  <= '0;
      n_tail_q  <= '0;
      n_cnt_q   <= '0;
      l_head_q  <= '0;
      l_tail_q  <= '0;
      l_cnt_q   <= '0;
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      state_q   <= state_d;
      sel_q     <= sel_d;
      n_head_q  <= n_head_d;
      n_tail_q  <= n_tail_d;
      n_cnt_q   <= n_cnt_d;
      l_head_q  <= l_head_d;
      l_tail_q  <= l_tail_d;
      l_cnt_q   <= l_cnt_d;
      res_cnt_q <= res_cnt_d;
      if (res_push) begin
        res_wr_q <= ~res_wr_q;
      end
      if (res_pop) begin
        res_rd_q <= ~res_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_slot_q[res_wr_q] <= res_in;
    end
  end

  assign res_valid_o = (res_cnt_q != 2'd0);
  assign res_o       = res_slot_q[res_rd_q];

endmodule
